// ===== rtl/core/lsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the lookahead stereo compressor.
// Depends on nothing; every other file of the block but lsc_ram imports it.
package lsc_pkg;

	// Sample and storage geometry. The delay depth must be a power of two.
	localparam int SAMPLE_W    = 24;
	localparam int DELAY_DEPTH = 16384;
	localparam int DAW         = $clog2(DELAY_DEPTH);
	localparam int GAIN_W      = 17;
	localparam int MS_W        = 48;
	localparam int MUL_W       = 32;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int LOG_W       = 21;
	localparam int ENV_SHIFT   = SAMPLE_W - 17;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 112;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [GAIN_W-1:0]   UNITY      = 17'd65536;
	localparam logic [SAMPLE_W-1:0] THRESH_MIN = 24'd8;
	localparam logic [15:0]         EXP_MAX    = 16'd64880;
	localparam logic [MS_W-1:0]     SAMPLE_MAX = MS_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_GAIN       = 3'd0,
		REG_THRESHOLD        = 3'd1,
		REG_RATIO_EXPONENT   = 3'd2,
		REG_LOOKAHEAD_DELAY  = 3'd3,
		REG_ATTACK_COEFF     = 3'd4,
		REG_RELEASE_COEFF    = 3'd5,
		REG_OUTPUT_AMPLITUDE = 3'd6,
		REG_USE_SIDECHAIN    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] input_gain;
		logic [23:0] threshold;
		logic [15:0] ratio_exponent;
		logic [13:0] lookahead_delay;
		logic [16:0] attack_coeff;
		logic [15:0] release_coeff;
		logic [23:0] output_amplitude;
		logic        use_sidechain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		input_gain:       24'd65536,
		threshold:        24'd4194304,
		ratio_exponent:   16'd57344,
		lookahead_delay:  14'd0,
		attack_coeff:     17'd65536,
		release_coeff:    16'd94,
		output_amplitude: 24'd65536,
		use_sidechain:    1'b0
	};

	typedef struct packed {
		logic [GAIN_W-1:0]          envelope_now;
		logic [GAIN_W-1:0]          gain_now;
		logic signed [SAMPLE_W-1:0] right_out;
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] mono_out;
	} result_t;

	// Floor square root; used only at elaboration to build the exp2 table.
	function automatic logic [63:0] isqrt_f(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Entry k holds 2^(-2^(k-16)) in Q0.30, made by repeated square roots from 0.5.
	function automatic logic [15:0][29:0] exp_rom_f();
		logic [15:0][29:0] t;
		logic [63:0] c;
		c = isqrt_f(64'd1 << 59);
		for (int k = 15; k >= 0; k--) begin
			t[k] = c[29:0];
			c = isqrt_f(c << 30);
		end
		return t;
	endfunction

	localparam logic [15:0][29:0] EXP_ROM = exp_rom_f();

	// Magnitude of a signed sample.
	function automatic logic [SAMPLE_W-1:0] abs_f(input logic signed [SAMPLE_W-1:0] x);
		return x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
	endfunction

	// Applies a sign to a magnitude and saturates to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat_f(input logic [MS_W-1:0] mag,
			input logic neg);
		logic [SAMPLE_W-1:0] m;
		m = mag[SAMPLE_W-1:0];
		if (neg) begin
			if (mag > SAMPLE_MAX + MS_W'(1))
				return {1'b1, {(SAMPLE_W-1){1'b0}}};
			return $signed(SAMPLE_W'(~m + SAMPLE_W'(1)));
		end
		if (mag > SAMPLE_MAX)
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		return $signed(m);
	endfunction

	// Position of the leading one of a non-zero sample-wide value.
	function automatic logic [4:0] lead_one_f(input logic [SAMPLE_W-1:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < SAMPLE_W; i++) begin
			if (v[i])
				n = 5'(i);
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/lsc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lsc_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lsc_mul.sv =====
`timescale 1ns / 1ps
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on lsc_pkg for the operand width.
module lsc_mul (
	input  logic                       clk,
	input  logic [lsc_pkg::MUL_W-1:0]  a,
	input  logic [lsc_pkg::MUL_W-1:0]  b,
	output logic [lsc_pkg::PROD_W-1:0] p
);
	import lsc_pkg::*;

	logic [PROD_W-1:0] p_q;

	// The product is registered and is available in the cycle after the operands are presented.
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

// ===== rtl/core/lsc_core.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath: detector, square root, log2, exp2, gain smoothing and output.
// Depends on lsc_pkg, lsc_mul and lsc_ram.
module lsc_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsc_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [lsc_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [lsc_pkg::SAMPLE_W-1:0] right_in,
	input  logic signed [lsc_pkg::SAMPLE_W-1:0] key_in,
	input  logic                                out_free,
	output logic                                res_valid,
	output lsc_pkg::result_t                    res
);
	import lsc_pkg::*;

	typedef enum logic [24:0] {
		ST_IDLE     = 25'h0000001,
		ST_GAIN_L   = 25'h0000002,
		ST_GAIN_R   = 25'h0000004,
		ST_PEAK     = 25'h0000008,
		ST_POW      = 25'h0000010,
		ST_MSD      = 25'h0000020,
		ST_CQ_HI    = 25'h0000040,
		ST_CQ_LO    = 25'h0000080,
		ST_CQ_SUM   = 25'h0000100,
		ST_SQRT     = 25'h0000200,
		ST_LOG_INIT = 25'h0000400,
		ST_LOG_MUL  = 25'h0000800,
		ST_LOG_ACC  = 25'h0001000,
		ST_EXPO     = 25'h0002000,
		ST_EXP_INIT = 25'h0004000,
		ST_EXP_STEP = 25'h0008000,
		ST_EXP_ACC  = 25'h0010000,
		ST_EXP_FIN  = 25'h0020000,
		ST_GAIN_D   = 25'h0040000,
		ST_OL1      = 25'h0080000,
		ST_OL2      = 25'h0100000,
		ST_OL3      = 25'h0200000,
		ST_OR2      = 25'h0400000,
		ST_OR3      = 25'h0800000,
		ST_FIN      = 25'h1000000
	} state_t;

	state_t state_q, state_d;

	// Control state, set by reset: the gain to unity, the rest to zero.
	logic [MS_W-1:0]   ms_q;
	logic [GAIN_W-1:0] g_q;
	logic [DAW-1:0]    wp_q;
	logic              wrapped_q;

	// Payload and working registers.
	logic signed [SAMPLE_W-1:0] left_q, right_q, key_q, gl_q, gr_q, ol_q, or_q;
	logic [46:0]         d_q;
	logic [GAIN_W-1:0]   c_q;
	logic                up_q;
	logic                phase_q;
	logic [MS_W-1:0]     acc_q;
	logic [MS_W-1:0]     sq_src_q;
	logic [26:0]         sq_rem_q;
	logic [SAMPLE_W-1:0] sq_root_q;
	logic [4:0]          cnt_q;
	logic [SAMPLE_W-1:0] env_q;
	logic [30:0]         m_q;
	logic [LOG_W-1:0]    lg_q, le_q, lt_q;
	logic [3:0]          k_q;
	logic                log_sel_q;
	logic [5:0]          n_q;
	logic [15:0]         f_q;
	logic [30:0]         r_q;
	logic [GAIN_W-1:0]   target_q;
	logic                dvalid_q;

	// Shared multiplier.
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;

	lsc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Delay lines.
	logic [DAW-1:0]      rd_addr;
	logic [SAMPLE_W-1:0] ram_l, ram_r;
	logic                ram_we, ram_re;

	lsc_ram #(.W(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_ram_l (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (gl_q),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_l)
	);

	lsc_ram #(.W(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_ram_r (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (gr_q),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_r)
	);

	// Clamped or widened configuration values.
	logic [GAIN_W-1:0]   att, rel;
	logic [SAMPLE_W-1:0] thr;
	logic [15:0]         ex;
	logic [DAW-1:0]      la;

	assign att = (cfg.attack_coeff > UNITY) ? UNITY : cfg.attack_coeff;
	assign rel = GAIN_W'(cfg.release_coeff);
	assign thr = (cfg.threshold < THRESH_MIN) ? THRESH_MIN : cfg.threshold;
	assign ex  = (cfg.ratio_exponent > EXP_MAX) ? EXP_MAX : cfg.ratio_exponent;
	assign la  = (32'(cfg.lookahead_delay) > 32'(DELAY_DEPTH - 1)) ?
		DAW'(DELAY_DEPTH - 1) : DAW'(cfg.lookahead_delay);

	assign rd_addr = wp_q - la;
	assign ram_we  = (state_q == ST_POW);
	assign ram_re  = (state_q == ST_MSD);

	// Helper values shared by several steps.
	logic [MS_W-1:0]            rnd16, rup16, power, cq_step, ms_new, g_sum;
	logic [SAMPLE_W-1:0]        peak, abs_l, abs_r;
	logic signed [SAMPLE_W-1:0] dl, dr;
	logic [28:0]                sq_cat, sq_trial, sq_rem_n;
	logic                       sq_ge;
	logic [SAMPLE_W-1:0]        sq_root_n, log_v;
	logic [4:0]                 log_n;
	logic [31:0]                m2;
	logic [LOG_W-1:0]           lg_n, dlog;
	logic [21:0]                exp_a;
	logic [6:0]                 exp_s;
	logic [31:0]                exp_sum, exp_sh;
	logic [GAIN_W-1:0]          exp_tgt, gdiff;
	logic                       gdown, ms_up;
	logic signed [SAMPLE_W:0]   mono_sum;
	logic [SAMPLE_W-1:0]        env_sh;

	always_comb begin
		rnd16   = MS_W'((mul_p + PROD_W'(32768)) >> 16);
		rup16   = MS_W'((mul_p + PROD_W'(65535)) >> 16);
		power   = mul_p[MS_W-1:0];
		ms_up   = power > ms_q;
		cq_step = acc_q + rup16;
		ms_new  = up_q ? ms_q + cq_step : ms_q - cq_step;
		g_sum   = up_q ? MS_W'(g_q) + cq_step : MS_W'(g_q) - cq_step;

		abs_l = abs_f(gl_q);
		abs_r = abs_f(gr_q);
		peak  = cfg.use_sidechain ? abs_f(key_q) : ((abs_l > abs_r) ? abs_l : abs_r);
		dl    = dvalid_q ? $signed(ram_l) : '0;
		dr    = dvalid_q ? $signed(ram_r) : '0;

		// One restoring square-root digit.
		sq_cat    = {sq_rem_q, sq_src_q[MS_W-1:MS_W-2]};
		sq_trial  = 29'({sq_root_q, 2'b01});
		sq_ge     = sq_cat >= sq_trial;
		sq_rem_n  = sq_ge ? sq_cat - sq_trial : sq_cat;
		sq_root_n = {sq_root_q[SAMPLE_W-2:0], sq_ge};

		// log2 normalisation and one squaring step.
		log_v = log_sel_q ? thr : env_q;
		log_n = lead_one_f(log_v);
		m2    = mul_p[61:30];
		lg_n  = lg_q;
		lg_n[k_q] = lg_q[k_q] | m2[31];
		dlog  = (le_q > lt_q) ? le_q - lt_q : '0;

		// exp2 rounding back to Q1.16.
		exp_a   = rnd16[21:0];
		exp_s   = 7'(n_q) + 7'd14;
		exp_sum = 32'(r_q) + (32'd1 << (exp_s - 7'd1));
		exp_sh  = exp_sum >> exp_s;
		if (n_q > 6'd16)
			exp_tgt = (n_q == 6'd17 && r_q[30]) ? GAIN_W'(1) : '0;
		else if (exp_sh > 32'(UNITY))
			exp_tgt = UNITY;
		else
			exp_tgt = exp_sh[GAIN_W-1:0];

		gdown = target_q < g_q;
		gdiff = gdown ? g_q - target_q : target_q - g_q;

		mono_sum = {ol_q[SAMPLE_W-1], ol_q} + {or_q[SAMPLE_W-1], or_q};
		env_sh   = env_q >> ENV_SHIFT;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_GAIN_L: begin
				mul_a = MUL_W'(abs_f(left_q));
				mul_b = MUL_W'(cfg.input_gain);
			end
			ST_GAIN_R: begin
				mul_a = MUL_W'(abs_f(right_q));
				mul_b = MUL_W'(cfg.input_gain);
			end
			ST_POW: begin
				mul_a = MUL_W'(peak);
				mul_b = MUL_W'(peak);
			end
			ST_CQ_HI: begin
				mul_a = MUL_W'(d_q[46:16]);
				mul_b = MUL_W'(c_q);
			end
			ST_CQ_LO: begin
				mul_a = MUL_W'(d_q[15:0]);
				mul_b = MUL_W'(c_q);
			end
			ST_LOG_MUL: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			ST_EXPO: begin
				mul_a = MUL_W'(ex);
				mul_b = MUL_W'(dlog);
			end
			ST_EXP_STEP: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(EXP_ROM[k_q]);
			end
			ST_OL1: begin
				mul_a = MUL_W'(abs_f(dl));
				mul_b = MUL_W'(g_q);
			end
			ST_OL3: begin
				mul_a = MUL_W'(abs_f(dr));
				mul_b = MUL_W'(g_q);
			end
			ST_OL2, ST_OR2: begin
				mul_a = MUL_W'(rnd16[SAMPLE_W-1:0]);
				mul_b = MUL_W'(cfg.output_amplitude);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_GAIN_L;
			ST_GAIN_L:   state_d = ST_GAIN_R;
			ST_GAIN_R:   state_d = ST_PEAK;
			ST_PEAK:     state_d = ST_POW;
			ST_POW:      state_d = ST_MSD;
			ST_MSD:      state_d = ST_CQ_HI;
			ST_CQ_HI:    state_d = ST_CQ_LO;
			ST_CQ_LO:    state_d = ST_CQ_SUM;
			ST_CQ_SUM:   state_d = phase_q ? ST_OL1 : ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == '0)
					state_d = (sq_root_n > thr) ? ST_LOG_INIT : ST_GAIN_D;
			end
			ST_LOG_INIT: state_d = ST_LOG_MUL;
			ST_LOG_MUL:  state_d = ST_LOG_ACC;
			ST_LOG_ACC: begin
				if (k_q != '0)
					state_d = ST_LOG_MUL;
				else
					state_d = log_sel_q ? ST_EXPO : ST_LOG_INIT;
			end
			ST_EXPO:     state_d = ST_EXP_INIT;
			ST_EXP_INIT: state_d = ST_EXP_STEP;
			ST_EXP_STEP: begin
				if (f_q[k_q])
					state_d = ST_EXP_ACC;
				else if (k_q == '0)
					state_d = ST_EXP_FIN;
			end
			ST_EXP_ACC:  state_d = (k_q == '0) ? ST_EXP_FIN : ST_EXP_STEP;
			ST_EXP_FIN:  state_d = ST_GAIN_D;
			ST_GAIN_D:   state_d = ST_CQ_HI;
			ST_OL1:      state_d = ST_OL2;
			ST_OL2:      state_d = ST_OL3;
			ST_OL3:      state_d = ST_OR2;
			ST_OR2:      state_d = ST_OR3;
			ST_OR3:      state_d = ST_FIN;
			ST_FIN:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer state, detector state, smoothed gain and write pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ms_q      <= '0;
			g_q       <= UNITY;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MSD) begin
				wp_q <= wp_q + DAW'(1);
				if (wp_q == DAW'(DELAY_DEPTH - 1))
					wrapped_q <= 1'b1;
			end
			if (state_q == ST_CQ_SUM) begin
				if (phase_q)
					g_q <= (g_sum > MS_W'(UNITY)) ? UNITY : g_sum[GAIN_W-1:0];
				else
					ms_q <= ms_new;
			end
		end
	end

	// Working registers of each step.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				left_q  <= left_in;
				right_q <= right_in;
				key_q   <= key_in;
			end
			ST_GAIN_R: gl_q <= sat_f(rnd16, left_q[SAMPLE_W-1]);
			ST_PEAK:   gr_q <= sat_f(rnd16, right_q[SAMPLE_W-1]);
			ST_MSD: begin
				up_q     <= ms_up;
				d_q      <= ms_up ? 47'(power - ms_q) : 47'(ms_q - power);
				c_q      <= ms_up ? att : rel;
				phase_q  <= 1'b0;
				dvalid_q <= wrapped_q || (rd_addr <= wp_q);
			end
			ST_CQ_LO: acc_q <= rnd16 - rnd16 + mul_p[MS_W-1:0];
			ST_CQ_SUM: begin
				sq_src_q  <= ms_new;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				cnt_q     <= 5'(SAMPLE_W - 1);
			end
			ST_SQRT: begin
				sq_src_q  <= sq_src_q << 2;
				sq_rem_q  <= sq_rem_n[26:0];
				sq_root_q <= sq_root_n;
				cnt_q     <= cnt_q - 5'd1;
				log_sel_q <= 1'b0;
				target_q  <= UNITY;
				if (cnt_q == '0)
					env_q <= sq_root_n;
			end
			ST_LOG_INIT: begin
				m_q  <= 31'(log_v) << (5'd30 - log_n);
				lg_q <= {log_n, 16'd0};
				k_q  <= 4'd15;
			end
			ST_LOG_ACC: begin
				m_q  <= m2[31] ? m2[31:1] : m2[30:0];
				lg_q <= lg_n;
				k_q  <= k_q - 4'd1;
				if (k_q == '0) begin
					if (log_sel_q)
						lt_q <= lg_n;
					else
						le_q <= lg_n;
					log_sel_q <= 1'b1;
				end
			end
			ST_EXP_INIT: begin
				n_q <= exp_a[21:16];
				f_q <= exp_a[15:0];
				r_q <= 31'd1 << 30;
				k_q <= 4'd15;
			end
			ST_EXP_STEP: if (!f_q[k_q]) k_q <= k_q - 4'd1;
			ST_EXP_ACC: begin
				r_q <= mul_p[60:30];
				k_q <= k_q - 4'd1;
			end
			ST_EXP_FIN: target_q <= exp_tgt;
			ST_GAIN_D: begin
				up_q    <= !gdown;
				d_q     <= 47'(gdiff);
				c_q     <= gdown ? att : rel;
				phase_q <= 1'b1;
			end
			ST_OL3: ol_q <= sat_f(rnd16, dl[SAMPLE_W-1]);
			ST_OR3: or_q <= sat_f(rnd16, dr[SAMPLE_W-1]);
			default: ;
		endcase
	end

	// Result of the finished item.
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN) && out_free;

	always_comb begin
		res.mono_out     = mono_sum[SAMPLE_W:1];
		res.left_out     = ol_q;
		res.right_out    = or_q;
		res.gain_now     = g_q;
		res.envelope_now = (env_sh > SAMPLE_W'(UNITY)) ? UNITY : env_sh[GAIN_W-1:0];
	end

endmodule

// ===== rtl/core/lookahead_stereo_compressor.sv =====
`timescale 1ns / 1ps
// Top level: stream ports, configuration registers and the result register.
// Depends on lsc_pkg and lsc_core.

// One item is a stereo sample with a sidechain sample; it produces one result item.
// The block works on one item at a time; the log2 and exp2 steps run only when the
// envelope is above the threshold, and the next item is accepted in the idle state
// that follows the result. The work per item is set by the single shared 32 by 32
// multiplier and the sequencer around it: a restoring square root of 24 digits, two
// 16-step log2 squaring loops of a multiply and an accumulate state a step, and up to
// 16 exp2 multiplies. The delay lines need no clearing pass after reset: entries not yet
// written since reset read as zero. A finished result waits in the output register
// while the next item is accepted. Configuration is taken at any time but must only
// change while the block is idle.
module lookahead_stereo_compressor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// left_in [23:0], right_in [47:24], key_in [71:48]
	input  logic [lsc_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// mono_out [23:0], left_out [47:24], right_out [71:48], gain_now [88:72],
	// envelope_now [105:89], zero [111:106]
	output logic [lsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lsc_pkg::*;

	cfg_t    cfg_q;
	result_t out_q, res;
	logic    m_tvalid_q, res_valid, out_free;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_INPUT_GAIN:       cfg_q.input_gain       <= cfg_data[23:0];
				REG_THRESHOLD:        cfg_q.threshold        <= cfg_data[23:0];
				REG_RATIO_EXPONENT:   cfg_q.ratio_exponent   <= cfg_data[15:0];
				REG_LOOKAHEAD_DELAY:  cfg_q.lookahead_delay  <= cfg_data[13:0];
				REG_ATTACK_COEFF:     cfg_q.attack_coeff     <= cfg_data[16:0];
				REG_RELEASE_COEFF:    cfg_q.release_coeff    <= cfg_data[15:0];
				REG_OUTPUT_AMPLITUDE: cfg_q.output_amplitude <= cfg_data[23:0];
				REG_USE_SIDECHAIN:    cfg_q.use_sidechain    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	lsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.left_in   ($signed(s_tdata[23:0])),
		.right_in  ($signed(s_tdata[47:24])),
		.key_in    ($signed(s_tdata[71:48])),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register; the core only finishes when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_valid)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.envelope_now, out_q.gain_now, out_q.right_out,
		out_q.left_out, out_q.mono_out});

endmodule

// ===== rtl/core/lsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the lookahead stereo compressor, bound to the top level.
// Depends on lsc_pkg and the top-level port list.
module lsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [lsc_pkg::IN_TDATA_W-1:0]    s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lsc_pkg::*;

	logic signed [SAMPLE_W:0] lr_sum;

	assign lr_sum = $signed({m_tdata[47], m_tdata[47:24]}) +
		$signed({m_tdata[71], m_tdata[71:48]});

	// A stalled result item holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// The mono field is the floored mean of the two channels.
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:0] == lr_sum[SAMPLE_W:1])
		else $error("mono field does not match the channel mean");

	// Gain and envelope never exceed unity.
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[88:72] <= UNITY)
		else $error("gain above unity");

	a_env_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[105:89] <= UNITY)
		else $error("envelope above unity");

	// The block is busy in the cycle after it accepts an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

endmodule

bind lookahead_stereo_compressor lsc_checker u_lsc_checker (.*);
